/* hdl/interval_set_merge_subtract_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef INTERVAL_SET_MERGE_SUBTRACT_UNIT_MACROS_SVH
`define INTERVAL_SET_MERGE_SUBTRACT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define ISMSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define ISMSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/ismsu_pkg.sv */
// ----------------------------------------------------------------------------
// ismsu_pkg
// Types and codes shared by the interval set unit and its checker.
// ----------------------------------------------------------------------------
package ismsu_pkg;

    localparam int SPAN_W = 37;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_ADD    = 2'd0;
    localparam t_req REQ_REMOVE = 2'd1;
    localparam t_req REQ_CLEAR  = 2'd2;
    localparam t_req REQ_READ   = 2'd3;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_OVF  = 2'd1;
    localparam t_status STAT_BADX = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PROC,
        ST_TAIL,
        ST_FLUSH,
        ST_DONE
    } t_state;

endpackage

/* hdl/interval_set_merge_subtract_unit.sv */
// ----------------------------------------------------------------------------
// interval_set_merge_subtract_unit
// Sorted table of disjoint inclusive ranges with add (merge), remove (cut),
// clear and read requests, kept in a ping-pong pair of table banks.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  request  | i_start, o_busy            | i_req_type, i_range_low/high, i_entry_index
//  result   | o_valid (one-cycle strobe) | o_status, o_interval_count, o_total_span,
//           |                            | o_entry_low, o_entry_high
//
// An add or remove walks the stored entries, a table read then a merge/trim
// step per entry (the step repeated for a split), reading one bank and writing
// the other; an add then places and flushes the pending range. A clear goes
// straight to the done state, and a read fetches its entry first.
// o_busy stays high from acceptance until the cycle the result strobes.
// Reset is synchronous and empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_set_merge_subtract_unit #(
    parameter int MAX_RANGES  = 32,
    parameter int BOUND_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  ismsu_pkg::t_req                 i_req_type,
    input  logic [31:0]                     i_range_low,
    input  logic [31:0]                     i_range_high,
    input  logic [4:0]                      i_entry_index,
    output logic                            o_valid,
    output ismsu_pkg::t_status              o_status,
    output logic [5:0]                      o_interval_count,
    output logic [ismsu_pkg::SPAN_W-1:0]    o_total_span,
    output logic [31:0]                     o_entry_low,
    output logic [31:0]                     o_entry_high
);
    import ismsu_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 2);
    localparam int BW = BOUND_WIDTH;
    localparam int XW = (CW > 5) ? CW : 5;

    logic [BW-1:0] mem_lo [2**(AW+1)];
    logic [BW-1:0] mem_hi [2**(AW+1)];

    t_state              r_state, n_state;
    t_req                r_op;
    logic [BW-1:0]       r_lo, r_hi;
    logic [4:0]          r_idx;
    logic                r_bank, n_bank;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [SPAN_W-1:0]   r_span, n_span;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_n, n_n;
    logic [SPAN_W-1:0]   r_acc, n_acc;
    logic                r_placed, n_placed;
    logic                r_pv, n_pv;
    logic [BW-1:0]       r_plo, n_plo, r_phi, n_phi;
    logic                r_half, n_half;
    logic [BW-1:0]       r_rd_lo, r_rd_hi;
    logic                r_busy, n_busy;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [5:0]          r_ocnt, n_ocnt;
    logic [SPAN_W-1:0]   r_ospan, n_ospan;
    logic [31:0]         r_elo, n_elo, r_ehi, n_ehi;

    logic                accept;
    logic                adv;
    logic                last;
    logic                we;
    logic [AW:0]         waddr, raddr;
    logic [BW-1:0]       wl, wh;
    logic                emit;
    logic [BW-1:0]       el, eh;
    logic                psh;
    logic [BW-1:0]       xl, xh;
    logic                ovf;
    logic [BW-1:0]       in_lo, in_hi;

    assign accept = i_start && !r_busy;
    assign in_lo  = BW'(i_range_low);
    assign in_hi  = BW'(i_range_high);
    assign last   = (r_i + CW'(1)) == r_cnt;
    assign ovf    = r_n > CW'(MAX_RANGES);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ADD: begin
                            if (in_hi < in_lo)
                                n_state = ST_DONE;
                            else if (r_cnt == '0)
                                n_state = ST_TAIL;
                            else
                                n_state = ST_FETCH;
                        end
                        REQ_REMOVE: begin
                            if (in_hi < in_lo || r_cnt == '0)
                                n_state = ST_DONE;
                            else
                                n_state = ST_FETCH;
                        end
                        REQ_READ: n_state = ST_FETCH;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_FETCH: n_state = (r_op == REQ_READ) ? ST_DONE : ST_PROC;
            ST_PROC: begin
                if (adv) begin
                    if (!last)
                        n_state = ST_FETCH;
                    else if (r_op == REQ_ADD)
                        n_state = ST_TAIL;
                    else
                        n_state = ST_DONE;
                end
            end
            ST_TAIL:  n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_bank   = r_bank;
        n_cnt    = r_cnt;
        n_span   = r_span;
        n_i      = r_i;
        n_n      = r_n;
        n_acc    = r_acc;
        n_placed = r_placed;
        n_pv     = r_pv;
        n_plo    = r_plo;
        n_phi    = r_phi;
        n_half   = r_half;
        n_busy   = r_busy;
        n_valid  = 1'b0;
        n_status = r_status;
        n_ocnt   = r_ocnt;
        n_ospan  = r_ospan;
        n_elo    = r_elo;
        n_ehi    = r_ehi;
        adv      = 1'b0;
        emit     = 1'b0;
        el       = r_rd_lo;
        eh       = r_rd_hi;
        psh      = 1'b0;
        xl       = r_rd_lo;
        xh       = r_rd_hi;
        raddr    = {r_bank, AW'(r_i)};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_busy   = 1'b1;
                    n_i      = '0;
                    n_n      = '0;
                    n_acc    = '0;
                    n_placed = 1'b0;
                    n_pv     = 1'b0;
                    n_half   = 1'b0;
                end
            end
            ST_FETCH: begin
                if (r_op == REQ_READ)
                    raddr = {r_bank, AW'(r_idx)};
            end
            ST_PROC: begin
                if (r_op == REQ_ADD) begin
                    psh = 1'b1;
                    if (!r_placed && r_rd_lo >= r_lo) begin
                        xl       = r_lo;
                        xh       = r_hi;
                        n_placed = 1'b1;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    if (r_rd_hi < r_lo || r_rd_lo > r_hi) begin
                        emit = 1'b1;
                        adv  = 1'b1;
                    end else if (r_rd_lo < r_lo && !r_half) begin
                        // Left piece first; a split comes back for the right piece.
                        emit = 1'b1;
                        eh   = r_lo - BW'(1);
                        if (r_rd_hi > r_hi)
                            n_half = 1'b1;
                        else
                            adv = 1'b1;
                    end else begin
                        if (r_rd_hi > r_hi) begin
                            emit = 1'b1;
                            el   = r_hi + BW'(1);
                        end
                        n_half = 1'b0;
                        adv    = 1'b1;
                    end
                end
                if (adv)
                    n_i = r_i + CW'(1);
            end
            ST_TAIL: begin
                if (!r_placed) begin
                    psh      = 1'b1;
                    xl       = r_lo;
                    xh       = r_hi;
                    n_placed = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (r_pv) begin
                    emit = 1'b1;
                    el   = r_plo;
                    eh   = r_phi;
                end
            end
            ST_DONE: begin
                n_busy  = 1'b0;
                n_valid = 1'b1;
                n_elo   = '0;
                n_ehi   = '0;
                n_status = STAT_OK;
                case (r_op)
                    REQ_CLEAR: begin
                        n_cnt  = '0;
                        n_span = '0;
                    end
                    REQ_READ: begin
                        if (XW'(r_idx) < XW'(r_cnt) && r_cnt != '0) begin
                            n_elo = 32'(r_rd_lo);
                            n_ehi = 32'(r_rd_hi);
                        end else begin
                            n_status = STAT_BADX;
                        end
                    end
                    default: begin
                        if (r_hi >= r_lo) begin
                            if (ovf) begin
                                n_status = STAT_OVF;
                            end else begin
                                n_bank = !r_bank;
                                n_cnt  = r_n;
                                n_span = r_acc;
                            end
                        end
                    end
                endcase
                n_ocnt  = 6'(n_cnt);
                n_ospan = n_span;
            end
            default: ;
        endcase

        // Merge into the pending range, or retire it and start a new one.
        if (psh) begin
            if (r_pv && ({1'b0, xl} <= ({1'b0, r_phi} + (BW+1)'(1)))) begin
                if (xh > r_phi)
                    n_phi = xh;
            end else begin
                if (r_pv) begin
                    emit = 1'b1;
                    el   = r_plo;
                    eh   = r_phi;
                end
                n_pv  = 1'b1;
                n_plo = xl;
                n_phi = xh;
            end
        end

        we    = 1'b0;
        waddr = {!r_bank, AW'(r_n)};
        wl    = el;
        wh    = eh;
        if (emit) begin
            we    = r_n < CW'(MAX_RANGES);
            n_n   = r_n + CW'(1);
            n_acc = r_acc + SPAN_W'(eh - el);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_span   <= '0;
            r_busy   <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= STAT_OK;
            r_ocnt   <= '0;
            r_ospan  <= '0;
            r_elo    <= '0;
            r_ehi    <= '0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_cnt    <= n_cnt;
            r_span   <= n_span;
            r_busy   <= n_busy;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_ocnt   <= n_ocnt;
            r_ospan  <= n_ospan;
            r_elo    <= n_elo;
            r_ehi    <= n_ehi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req_type;
            r_lo  <= in_lo;
            r_hi  <= in_hi;
            r_idx <= i_entry_index;
        end
        r_i      <= n_i;
        r_n      <= n_n;
        r_acc    <= n_acc;
        r_placed <= n_placed;
        r_pv     <= n_pv;
        r_plo    <= n_plo;
        r_phi    <= n_phi;
        r_half   <= n_half;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_lo[waddr] <= wl;
            mem_hi[waddr] <= wh;
        end
        r_rd_lo <= mem_lo[raddr];
        r_rd_hi <= mem_hi[raddr];
    end

    assign o_busy           = r_busy;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_interval_count = r_ocnt;
    assign o_total_span     = r_ospan;
    assign o_entry_low      = r_elo;
    assign o_entry_high     = r_ehi;

endmodule

/* hdl/ismsu_checker.sv */
// ----------------------------------------------------------------------------
// ismsu_checker
// Port-level checks on the interval set unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "interval_set_merge_subtract_unit_macros.svh"

module ismsu_checker #(
    parameter int MAX_RANGES = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         o_valid,
    input ismsu_pkg::t_status           o_status,
    input logic [5:0]                   o_interval_count,
    input logic [31:0]                  o_entry_low,
    input logic [31:0]                  o_entry_high
);
    import ismsu_pkg::*;

    // A result strobe always ends the busy period of its transaction.
    `ISMSU_ASSERT_NOW(a_valid_not_busy, o_valid, !o_busy)
    `ISMSU_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy)
    // The count port is six bits wide, so the cap is only visible for small tables.
    `ISMSU_ASSERT_NOW(a_count_cap, o_valid,
                      MAX_RANGES > 63 || o_interval_count <= 6'(MAX_RANGES))
    // Only a successful read returns bounds.
    `ISMSU_ASSERT_NOW(a_bounds_zero, o_valid && o_status != STAT_OK,
                      o_entry_low == '0 && o_entry_high == '0)

endmodule

bind interval_set_merge_subtract_unit ismsu_checker #(.MAX_RANGES(MAX_RANGES)) u_ismsu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_interval_count (o_interval_count),
    .o_entry_low      (o_entry_low),
    .o_entry_high     (o_entry_high)
);
